[rtl/core/ddep_pkg.sv]
// Shared types, constants and helper functions for the decimal dimension parser.
`default_nettype none

package ddep_pkg;

    localparam logic [63:0] SCALE_NM = 64'd1000000;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NODIGIT = 2'd1;
    localparam logic [1:0] ST_DIVZ    = 2'd2;
    localparam logic [1:0] ST_OVF     = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_AVG  = 3'd5
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] a;
        logic [63:0] bmag;
        logic        bneg;
        logic [1:0]  pre;
    } job_t;

    function automatic op_t op_of(input logic [7:0] ch);
        op_t res;
        case (ch)
            CH_PLUS:  res = OP_ADD;
            CH_MINUS: res = OP_SUB;
            CH_STAR:  res = OP_MUL;
            CH_SLASH: res = OP_DIV;
            CH_PIPE:  res = OP_AVG;
            default:  res = OP_NONE;
        endcase
        return res;
    endfunction

    // weight of the next digit; index 7 means digits add nothing
    function automatic logic [19:0] scale_of(input logic [2:0] idx);
        logic [19:0] res;
        case (idx)
            3'd0:    res = 20'd1000000;
            3'd1:    res = 20'd100000;
            3'd2:    res = 20'd10000;
            3'd3:    res = 20'd1000;
            3'd4:    res = 20'd100;
            3'd5:    res = 20'd10;
            3'd6:    res = 20'd1;
            default: res = 20'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ddep_front.sv]
// Character parser: builds operands and pushes one job per string.
`default_nettype none

module ddep_front
    import ddep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] character,
    input  wire logic       last_char,
    input  wire logic       q_full,
    output logic            job_push,
    output job_t            job
);

    typedef enum logic [2:0] {
        PH_SIGN = 3'b001,
        PH_INT  = 3'b010,
        PH_FRAC = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] first_reg, first_next;
    logic [2:0]  sidx_reg, sidx_next;
    op_t         op_reg, op_next;
    logic        seen_reg, seen_next;
    logic        ovf_reg, ovf_next;

    logic        accept;
    logic        is_digit;
    logic        is_mark;
    op_t         opc;
    logic [2:0]  sidx_inc;
    logic [23:0] add;
    logic [67:0] acc10;
    logic [67:0] sum_shift;
    logic [67:0] sum_plain;

    assign accept   = push && !q_full;
    assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
    assign is_mark  = character inside {CH_DOT, CH_COMMA};
    assign opc      = op_of(character);
    assign sidx_inc = (sidx_reg == 3'd7) ? sidx_reg : sidx_reg + 3'd1;
    assign add      = scale_of(sidx_reg) * {20'd0, character[3:0]};
    assign acc10    = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1);
    assign sum_shift = acc10 + {44'd0, add};
    assign sum_plain = {4'd0, acc_reg} + {44'd0, add};

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        first_next = first_reg;
        sidx_next  = sidx_reg;
        op_next    = op_reg;
        seen_next  = seen_reg;
        ovf_next   = ovf_reg;
        case (phase_reg)
            PH_INT:
            begin
                if (is_digit)
                begin
                    acc_next  = sum_shift[63:0];
                    ovf_next  = ovf_reg || (|sum_shift[67:63]);
                    seen_next = 1'b1;
                end
                else if (is_mark)
                begin
                    phase_next = PH_FRAC;
                    sidx_next  = sidx_inc;
                end
                else if (opc != OP_NONE && op_reg == OP_NONE)
                begin
                    op_next    = opc;
                    first_next = neg_reg ? (64'd0 - acc_reg) : acc_reg;
                    neg_next   = 1'b0;
                    acc_next   = 64'd0;
                    sidx_next  = 3'd0;
                    phase_next = PH_SIGN;
                end
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    acc_next  = sum_plain[63:0];
                    ovf_next  = ovf_reg || (|sum_plain[67:63]);
                    seen_next = 1'b1;
                    sidx_next = sidx_inc;
                end
                else if (opc != OP_NONE && op_reg == OP_NONE)
                begin
                    op_next    = opc;
                    first_next = neg_reg ? (64'd0 - acc_reg) : acc_reg;
                    neg_next   = 1'b0;
                    acc_next   = 64'd0;
                    sidx_next  = 3'd0;
                    phase_next = PH_SIGN;
                end
            end
            default:
            begin
                if (character == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT;
                end
                else if (is_mark)
                begin
                    phase_next = PH_FRAC;
                    sidx_next  = sidx_inc;
                end
                else if (is_digit)
                begin
                    acc_next   = sum_plain[63:0];
                    ovf_next   = ovf_reg || (|sum_plain[67:63]);
                    seen_next  = 1'b1;
                    phase_next = PH_INT;
                end
            end
        endcase
    end

    assign job_push = accept && last_char;

    always_comb
    begin
        job.op   = op_next;
        job.a    = first_next;
        job.bmag = acc_next;
        job.bneg = neg_next;
        if (!seen_next)
            job.pre = ST_NODIGIT;
        else if (ovf_next)
            job.pre = ST_OVF;
        else
            job.pre = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIGN;
            neg_reg   <= 1'b0;
            acc_reg   <= 64'd0;
            first_reg <= 64'd0;
            sidx_reg  <= 3'd0;
            op_reg    <= OP_NONE;
            seen_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                phase_reg <= PH_SIGN;
                neg_reg   <= 1'b0;
                acc_reg   <= 64'd0;
                first_reg <= 64'd0;
                sidx_reg  <= 3'd0;
                op_reg    <= OP_NONE;
                seen_reg  <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                first_reg <= first_next;
                sidx_reg  <= sidx_next;
                op_reg    <= op_next;
                seen_reg  <= seen_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/ddep_queue.sv]
// Two-entry job queue between parser and arithmetic back end.
`default_nettype none

module ddep_queue
    import ddep_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_job,
    output logic      full,
    input  wire logic rd_en,
    output job_t      rd_job,
    output logic      empty
);

    job_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_wr ? !wptr_reg : wptr_reg;
        rptr_next = do_rd ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ddep_back.sv]
// Arithmetic back end: combines operands, multiplies and divides serially, holds the result.
`default_nettype none

module ddep_back
    import ddep_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire job_t               q_job,
    output logic                    q_pop,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [63:0]      value_nm,
    output logic        [1:0]       status
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_AVG  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIT  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t       state_reg, state_next;
    op_t          op_reg, op_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [1:0]   pre_reg, pre_next;
    logic [63:0]  x_reg, x_next;
    logic [63:0]  y_reg, y_next;
    logic [63:0]  d_reg, d_next;
    logic         neg_reg, neg_next;
    logic [127:0] prod_reg, prod_next;
    logic [63:0]  rem_reg, rem_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [63:0]  res_val_reg, res_val_next;
    logic [1:0]   res_st_reg, res_st_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_val_reg, out_val_next;
    logic [1:0]   out_st_reg, out_st_next;

    logic [63:0]  sum_ab;
    logic [63:0]  dif_ab;
    logic [63:0]  a_abs;
    logic [63:0]  b_abs;
    logic [31:0]  xs;
    logic [31:0]  ys;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  r_sh;
    logic         ge;
    logic [64:0]  r_sub;
    logic [64:0]  avg_t;
    logic [63:0]  ql;
    logic         fit_ovf;
    logic         emit;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign value_nm = out_val_reg;
    assign status   = out_st_reg;

    assign sum_ab = a_reg + b_reg;
    assign dif_ab = a_reg - b_reg;
    assign a_abs  = a_reg[63] ? (64'd0 - a_reg) : a_reg;
    assign b_abs  = b_reg[63] ? (64'd0 - b_reg) : b_reg;

    assign xs    = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
    assign ys    = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
    assign pp    = {32'd0, xs} * {32'd0, ys};

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    assign r_sh  = {rem_reg, prod_reg[127]};
    assign ge    = (r_sh >= {1'b0, d_reg});
    assign r_sub = r_sh - {1'b0, d_reg};
    assign avg_t = prod_reg[64:0] + {64'd0, prod_reg[64]};
    assign ql    = prod_reg[63:0];
    assign fit_ovf = (prod_reg[127:64] != 64'd0)
                   || (ql[63] && !(neg_reg && ql == SIGN_BIT));

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        pre_next     = pre_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        d_next       = d_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    op_next    = q_job.op;
                    a_next     = q_job.a;
                    b_next     = q_job.bneg ? (64'd0 - q_job.bmag) : q_job.bmag;
                    pre_next   = q_job.pre;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                res_val_next = 64'd0;
                state_next   = S_EMIT;
                if (pre_reg != ST_OK)
                    res_st_next = pre_reg;
                else
                begin
                    res_st_next = ST_OK;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (a_reg[63] == b_reg[63] && sum_ab[63] != a_reg[63])
                                res_st_next = ST_OVF;
                            else
                                res_val_next = sum_ab;
                        end
                        OP_SUB:
                        begin
                            if (a_reg[63] != b_reg[63] && dif_ab[63] != a_reg[63])
                                res_st_next = ST_OVF;
                            else
                                res_val_next = dif_ab;
                        end
                        OP_AVG:
                        begin
                            prod_next  = {63'd0, {a_reg[63], a_reg} + {b_reg[63], b_reg}};
                            state_next = S_AVG;
                        end
                        OP_MUL, OP_DIV:
                        begin
                            if (op_reg == OP_DIV && b_reg == 64'd0)
                                res_st_next = ST_DIVZ;
                            else
                            begin
                                x_next     = a_abs;
                                y_next     = (op_reg == OP_MUL) ? b_abs : SCALE_NM;
                                d_next     = (op_reg == OP_MUL) ? SCALE_NM : b_abs;
                                neg_next   = a_reg[63] ^ b_reg[63];
                                prod_next  = 128'd0;
                                cnt_next   = 7'd0;
                                state_next = S_MUL;
                            end
                        end
                        default:
                            res_val_next = b_reg;
                    endcase
                end
            end
            S_AVG:
            begin
                res_val_next = avg_t[64:1];
                res_st_next  = ST_OK;
                state_next   = S_EMIT;
            end
            S_MUL:
            begin
                prod_next = prod_reg + pp_sh;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = 7'd0;
                    rem_next   = 64'd0;
                    state_next = S_DIV;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_DIV:
            begin
                rem_next  = ge ? r_sub[63:0] : r_sh[63:0];
                prod_next = {prod_reg[126:0], ge};
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                    state_next = S_FIT;
            end
            S_FIT:
            begin
                if (fit_ovf)
                begin
                    res_val_next = 64'd0;
                    res_st_next  = ST_OVF;
                end
                else
                begin
                    res_val_next = neg_reg ? (64'd0 - ql) : ql;
                    res_st_next  = ST_OK;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !pop;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_val_next   = res_val_reg;
            out_st_next    = res_st_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        pre_reg     <= pre_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        d_reg       <= d_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/decimal_dimension_expression_parser.sv]
// Top level of the decimal dimension expression parser.
//
//   channel   direction  handshake     payload
//   input     in         push / full   character[7:0], last_char
//   result    out        empty / pop   value_nm[63:0] signed, status[1:0]
//
// The parser takes a new character whenever full is low; one result per last_char.
// Add, subtract and plain values pass the back end states PREP and EMIT once it picks
// up the job; average adds AVG between them; multiply and divide run MUL (four 32x32
// partial products), a 128-step restoring divider (DIV) and FIT before EMIT.
// Reset clears all control state; no clearing pass.
// full rises while the two-entry job queue is full; a held result blocks the back end.
`default_nettype none

module decimal_dimension_expression_parser
    import ddep_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         character,
    input  wire logic               last_char,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [63:0]      value_nm,
    output logic        [1:0]       status
);

    logic job_push;
    job_t job_in;
    logic q_full;
    logic q_pop;
    job_t q_job;
    logic q_empty;

    assign full = q_full;

    ddep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .character (character),
        .last_char (last_char),
        .q_full    (q_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    ddep_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    ddep_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .value_nm (value_nm),
        .status   (status)
    );

endmodule

`default_nettype wire

[rtl/core/ddep_checker.sv]
// Port-level assertions for the decimal dimension expression parser, bound to the top level.
`default_nettype none

module ddep_checker
    import ddep_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [63:0] value_nm,
    input wire logic [1:0]  status
);

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (value_nm == 64'd0))
        else $error("error transaction carries nonzero value");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value_nm) && $stable(status)))
        else $error("stalled result transaction changed");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("handshake flag unknown");

endmodule

bind decimal_dimension_expression_parser ddep_checker u_ddep_checker (.*);

`default_nettype wire

[tb/tb_decimal_dimension_expression_parser.sv]
// Testbench for the decimal dimension expression parser: directed and random character strings.
module tb_decimal_dimension_expression_parser
    import ddep_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 750;
    localparam int DRAIN_CYCLES = 200;
    localparam bit [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum bit [1:0] {
        PH_SIGN = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } parse_phase_t;

    typedef struct packed {
        bit [63:0] value;
        bit [1:0]  status;
    } length_result_t;

    class length_scoreboard;
        parse_phase_t   phase;
        bit             negative;
        bit [63:0]      magnitude;
        bit [63:0]      left_operand;
        bit [19:0]      weight;
        op_t            pending_op;
        bit             any_digit;
        bit             parse_overflow;
        length_result_t expected_lengths[$];
        int             errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase = PH_SIGN;
            negative = 0;
            magnitude = 0;
            left_operand = 0;
            weight = SCALE_NM[19:0];
            pending_op = OP_NONE;
            any_digit = 0;
            parse_overflow = 0;
        endfunction

        function void add_digit(bit [3:0] d, bit shift);
            bit [63:0] add;
            add = weight * d;
            if (shift)
            begin
                if (magnitude > (MAX_POS - add) / 64'd10)
                    parse_overflow = 1;
                magnitude = magnitude * 64'd10 + add;
            end
            else
            begin
                if (magnitude > MAX_POS - add)
                    parse_overflow = 1;
                magnitude = magnitude + add;
            end
            any_digit = 1;
        endfunction

        function void take_op(op_t op);
            pending_op = op;
            left_operand = negative ? -magnitude : magnitude;
            negative = 0;
            magnitude = 0;
            weight = SCALE_NM[19:0];
            phase = PH_SIGN;
        endfunction

        function void parse_char(bit [7:0] ch);
            bit  is_digit;
            bit  is_mark;
            op_t op;
            is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
            is_mark = (ch == CH_DOT) || (ch == CH_COMMA);
            case (ch)
                CH_PLUS:  op = OP_ADD;
                CH_MINUS: op = OP_SUB;
                CH_STAR:  op = OP_MUL;
                CH_SLASH: op = OP_DIV;
                CH_PIPE:  op = OP_AVG;
                default:  op = OP_NONE;
            endcase
            case (phase)
                PH_INT:
                begin
                    if (is_digit)
                        add_digit(ch[3:0], 1);
                    else if (is_mark)
                    begin
                        phase = PH_FRAC;
                        weight = weight / 20'd10;
                    end
                    else if (op != OP_NONE && pending_op == OP_NONE)
                        take_op(op);
                end
                PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        add_digit(ch[3:0], 0);
                        weight = weight / 20'd10;
                    end
                    else if (op != OP_NONE && pending_op == OP_NONE)
                        take_op(op);
                end
                default:
                begin
                    if (ch == CH_MINUS)
                    begin
                        negative = 1;
                        phase = PH_INT;
                    end
                    else if (is_mark)
                    begin
                        phase = PH_FRAC;
                        weight = weight / 20'd10;
                    end
                    else if (is_digit)
                    begin
                        add_digit(ch[3:0], 0);
                        phase = PH_INT;
                    end
                end
            endcase
        endfunction

        function bit fit_signed(bit neg, bit [127:0] q, output bit [63:0] res);
            res = 0;
            if (q[127:64] != 0)
                return 0;
            if (q[63:0] > MAX_POS && !(neg && q[63:0] == SIGN_BIT))
                return 0;
            res = neg ? -q[63:0] : q[63:0];
            return 1;
        endfunction

        function bit [1:0] combine(output bit [63:0] res);
            bit [63:0]  a;
            bit [63:0]  b;
            bit [63:0]  r;
            bit [63:0]  t;
            bit [63:0]  ma;
            bit [63:0]  mb;
            bit [64:0]  s;
            bit [127:0] q;
            bit         neg;
            a = left_operand;
            b = negative ? -magnitude : magnitude;
            res = 0;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            neg = a[63] ^ b[63];
            case (pending_op)
                OP_ADD:
                begin
                    r = a + b;
                    t = (a ^ r) & (b ^ r);
                    if (t[63])
                        return ST_OVF;
                    res = r;
                    return ST_OK;
                end
                OP_SUB:
                begin
                    r = a - b;
                    t = (a ^ b) & (a ^ r);
                    if (t[63])
                        return ST_OVF;
                    res = r;
                    return ST_OK;
                end
                OP_AVG:
                begin
                    // exact sum, halved toward zero
                    s = {a[63], a} + {b[63], b};
                    if (s[64] && s[0])
                        s = s + 65'd1;
                    res = s[64:1];
                    return ST_OK;
                end
                OP_MUL:
                begin
                    q = {64'd0, ma} * {64'd0, mb};
                    q = q / {64'd0, SCALE_NM};
                    return fit_signed(neg, q, res) ? ST_OK : ST_OVF;
                end
                OP_DIV:
                begin
                    if (b == 0)
                        return ST_DIVZ;
                    q = {64'd0, ma} * {64'd0, SCALE_NM};
                    q = q / {64'd0, mb};
                    return fit_signed(neg, q, res) ? ST_OK : ST_OVF;
                end
                default:
                begin
                    res = b;
                    return ST_OK;
                end
            endcase
        endfunction

        function void note_input(bit [7:0] ch, bit last);
            length_result_t r;
            bit [63:0]      v;
            bit [1:0]       st;
            parse_char(ch);
            if (!last)
                return;
            v = 0;
            if (!any_digit)
                st = ST_NODIGIT;
            else if (parse_overflow)
                st = ST_OVF;
            else
                st = combine(v);
            if (st != ST_OK)
                v = 0;
            r.value = v;
            r.status = st;
            expected_lengths.push_back(r);
            clear();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [63:0] v, logic [1:0] st);
            length_result_t e;
            if (expected_lengths.size() == 0)
            begin
                report($sformatf("unexpected transaction value_nm=%0d status=%0d",
                                 $signed(v), st));
                return;
            end
            e = expected_lengths.pop_front();
            if (v !== e.value)
                report($sformatf("value_nm %0d, expected %0d", $signed(v), $signed(e.value)));
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
        endtask

        function int pending();
            return expected_lengths.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         character;
    logic               last_char;
    logic               empty;
    logic               pop;
    logic signed [63:0] value_nm;
    logic [1:0]         status;

    length_scoreboard board;
    int               cycles;
    int               items_sent;
    bit               send_steady;
    bit               take_steady;
    bit [7:0]         text[$];
    string            symbols = "0123456789.,+-*/|";

    decimal_dimension_expression_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .character (character),
        .last_char (last_char),
        .empty     (empty),
        .pop       (pop),
        .value_nm  (value_nm),
        .status    (status)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task send_char(bit [7:0] ch, bit last);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            push <= 0;
            repeat (gap) @(posedge clk);
        end
        push <= 1;
        character <= ch;
        last_char <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_input(ch, last);
        items_sent++;
        if ($urandom_range(0, 49) == 0)
            send_steady = !send_steady;
    endtask

    task send_str(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task send_text();
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    function void build_operand();
        int n;
        if ($urandom_range(0, 19) == 0)
            return;
        if ($urandom_range(0, 9) == 0)
            text.push_back(CH_PLUS);
        if ($urandom_range(0, 2) == 0)
            text.push_back(CH_MINUS);
        // long integer parts drive the overflow paths
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
        repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if (n == 0 || $urandom_range(0, 2) == 0)
        begin
            text.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
            repeat ($urandom_range(0, 9)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0)
            text.push_back(8'($urandom_range(0, 255)));
    endfunction

    function void build_text();
        text.delete();
        case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
            1: repeat ($urandom_range(1, 8)) text.push_back(symbols[$urandom_range(0, 16)]);
            default:
            begin
                build_operand();
                if ($urandom_range(0, 9) < 7)
                begin
                    text.push_back(symbols[$urandom_range(12, 16)]);
                    build_operand();
                end
            end
        endcase
        if (text.size() == 0)
            text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    task collect_results();
        int gap;
        forever
        begin
            gap = take_steady ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                pop <= 0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            board.check_result(value_nm, status);
            if ($urandom_range(0, 19) == 0)
                take_steady = !take_steady;
        end
    endtask

    initial
    begin
        board = new();
        rst_n <= 0;
        push <= 0;
        pop <= 0;
        character <= 0;
        last_char <= 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        fork
            collect_results();
        join_none

        send_char(8'h80, 0);
        send_char(8'h00, 1);
        send_char(8'hFF, 0);
        send_str("-1.5,2*2");
        send_str("5/");
        send_str("--5");
        send_str("+5|-3");
        send_str("9/8");
        send_str("1+2");

        while (items_sent < ITEM_TARGET)
        begin
            build_text();
            send_text();
        end
        push <= 0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/ddep_pkg.sv
rtl/core/ddep_front.sv
rtl/core/ddep_queue.sv
rtl/core/ddep_back.sv
rtl/core/decimal_dimension_expression_parser.sv
rtl/core/ddep_checker.sv
tb/tb_decimal_dimension_expression_parser.sv
